// ----- rtl/palette_framebuffer_rng_key_device_assert.svh -----
// Assertion helpers used by the RTL.
`ifndef PALETTE_FRAMEBUFFER_RNG_KEY_DEVICE_ASSERT_SVH
`define PALETTE_FRAMEBUFFER_RNG_KEY_DEVICE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define PFRKD_ASSERT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define PFRKD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- rtl/pfrkd_pkg.sv -----
package pfrkd_pkg;

  localparam int unsigned MAX_WIDTH_DEF      = 256;
  localparam int unsigned MAX_HEIGHT_DEF     = 128;
  localparam int unsigned KEY_RING_DEPTH_DEF = 256;
  localparam int unsigned PALETTE_DEPTH      = 256;

  // wrapped coordinates never exceed 1023
  localparam int unsigned COORD_W     = 10;
  localparam int unsigned DIV_STEPS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [63:0] RNG_RESET    = 64'h9e3779b97f4a7c15;
  localparam logic [8:0]  WIDTH_RESET  = 9'd64;
  localparam logic [7:0]  HEIGHT_RESET = 8'd48;

  typedef enum logic [2:0] {
    REQ_PLOT   = 3'd0,
    REQ_CLEAR  = 3'd1,
    REQ_PAL    = 3'd2,
    REQ_RAND   = 3'd3,
    REQ_SEED   = 3'd4,
    REQ_PUSH   = 3'd5,
    REQ_POP    = 3'd6,
    REQ_READ   = 3'd7
  } req_e;

  typedef enum logic {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_e;

  typedef struct packed {
    req_e               req;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [7:0]         color;
    logic [7:0]         pal_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [63:0]        seed;
    logic [7:0]         key_in;
  } cmd_t;

  typedef logic [PALETTE_DEPTH-1:0][23:0] pal_tbl_t;

  function automatic logic [7:0] cube_level(int k);
    return (k == 0) ? 8'd0 : 8'(55 + k * 40);
  endfunction

  function automatic pal_tbl_t xterm_table();
    pal_tbl_t   t;
    int         n;
    logic [7:0] v;
    t     = '0;
    t[0]  = 24'h000000; t[1]  = 24'haa0000; t[2]  = 24'h00aa00; t[3]  = 24'haa5500;
    t[4]  = 24'h0000aa; t[5]  = 24'haa00aa; t[6]  = 24'h00aaaa; t[7]  = 24'haaaaaa;
    t[8]  = 24'h555555; t[9]  = 24'hff5555; t[10] = 24'h55ff55; t[11] = 24'hffff55;
    t[12] = 24'h5555ff; t[13] = 24'hff55ff; t[14] = 24'h55ffff; t[15] = 24'hffffff;
    n = 16;
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          t[n] = {cube_level(r), cube_level(g), cube_level(b)};
          n++;
        end
      end
    end
    for (int i = 0; i < 24; i++) begin
      v = 8'(8 + i * 10);
      t[232 + i] = {v, v, v};
    end
    return t;
  endfunction

  localparam pal_tbl_t XTERM = xterm_table();

endpackage

// ----- rtl/pfrkd_if.sv -----
interface pfrkd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] x;
  logic [15:0] y;
  logic [7:0]  color;
  logic [7:0]  pal_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [63:0] seed;
  logic [7:0]  key_in;

  modport source (output valid, req_type, x, y, color, pal_index, red, green, blue, seed,
                  key_in, input ready);
  modport sink (input valid, req_type, x, y, color, pal_index, red, green, blue, seed,
                key_in, output ready);
endinterface

interface pfrkd_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rand_byte;
  logic        key_got;
  logic [7:0]  key_char;
  logic [23:0] pixel_color;

  modport source (output valid, rand_byte, key_got, key_char, pixel_color, input ready);
  modport sink (input valid, rand_byte, key_got, key_char, pixel_color, output ready);
endinterface

// ----- rtl/palette_framebuffer_rng_key_device.sv -----
// Indexed framebuffer, palette, xorshift64 source and keyboard byte ring.
// req channel: one transaction per request (plot, clear, palette set, rand
// next, set seed, key push, key pop, read pixel). rsp channel: exactly one
// transaction per request, in order, with rand_byte, key_got, key_char and
// pixel_color (fields unused by the request read zero).
// Config: cfg_we_i writes screen_width (index 0) or screen_height (index 1);
// the user must do so while the block is idle, which the block does not
// enforce. x and y wrap modulo the effective sizes. Flow: the front pushes
// most requests directly, plot and read pixel after the 16-step remainder
// unit; the back answers most directly, a pop from a non-empty ring after a
// ring read, read pixel after framebuffer and palette reads, and clear after
// a sweep one pixel a cycle. A two-entry queue parts front and back, so
// requests keep arriving while the back is busy or the response is stalled
// until it fills; the response register holds its transaction until rsp.ready.
// Reset: framebuffer is swept to zero over all MAX_WIDTH*MAX_HEIGHT cells with
// req.ready low; palette reads the xterm layout until entries are written.
module palette_framebuffer_rng_key_device #(
  parameter int unsigned MAX_WIDTH      = pfrkd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT     = pfrkd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned KEY_RING_DEPTH = pfrkd_pkg::KEY_RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfrkd_req_if.sink   req,
  pfrkd_rsp_if.source rsp,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [8:0]  cfg_data_i
);

  pfrkd_pkg::cmd_t f_cmd, q_cmd;
  logic            push, full, pop, empty, init_busy;

  pfrkd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .init_busy_i (init_busy),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (f_cmd)
  );

  pfrkd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (f_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (q_cmd)
  );

  pfrkd_back #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .KEY_RING_DEPTH (KEY_RING_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .cmd_i       (q_cmd),
    .pop_o       (pop),
    .init_busy_o (init_busy),
    .rsp         (rsp)
  );

endmodule

// ----- rtl/pfrkd_front.sv -----
module pfrkd_front #(
  parameter int unsigned MAX_WIDTH  = pfrkd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = pfrkd_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  pfrkd_req_if.sink         req,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              init_busy_i,
  input  logic              full_i,
  output logic              push_o,
  output pfrkd_pkg::cmd_t   cmd_o
);

  localparam int unsigned EW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EH = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = ((EW > EH) ? EW : EH) + 1;
  localparam int unsigned CW = $clog2(pfrkd_pkg::DIV_STEPS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PUSH = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [8:0]      width_q;
  logic [7:0]      height_q;
  logic [RW-1:0]   eff_w, eff_h;
  logic [RW-1:0]   rem_x_q, rem_y_q, sx, sy, nx, ny;
  logic [15:0]     xs_q, ys_q;
  logic [CW-1:0]   cnt_q;
  pfrkd_pkg::cmd_t cmd_q;
  logic            accept;

  always_comb begin
    if (width_q == '0) begin
      eff_w = RW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = RW'(MAX_WIDTH);
    end else begin
      eff_w = RW'(width_q);
    end
    if (height_q == '0) begin
      eff_h = RW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(height_q);
    end
  end

  // one restoring step per cycle: remainder stays below the divisor
  assign sx = {rem_x_q[RW-2:0], xs_q[15]};
  assign sy = {rem_y_q[RW-2:0], ys_q[15]};
  assign nx = (sx >= eff_w) ? sx - eff_w : sx;
  assign ny = (sy >= eff_h) ? sy - eff_h : sy;

  assign req.ready = (state_q == ST_IDLE) && !init_busy_i;
  assign accept    = req.valid && req.ready;
  assign push_o    = (state_q == ST_PUSH) && !full_i;

  always_comb begin
    cmd_o    = cmd_q;
    cmd_o.px = pfrkd_pkg::COORD_W'(rem_x_q);
    cmd_o.py = pfrkd_pkg::COORD_W'(rem_y_q);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (pfrkd_pkg::req_e'(req.req_type) inside {pfrkd_pkg::REQ_PLOT,
                                                       pfrkd_pkg::REQ_READ}) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_DIV: begin
        if (cnt_q == CW'(1)) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      width_q  <= pfrkd_pkg::WIDTH_RESET;
      height_q <= pfrkd_pkg::HEIGHT_RESET;
      cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == pfrkd_pkg::CFG_WIDTH) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i[7:0];
        end
      end
      if (accept) begin
        cnt_q <= CW'(pfrkd_pkg::DIV_STEPS);
      end else if (state_q == ST_DIV) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.req       <= pfrkd_pkg::req_e'(req.req_type);
      cmd_q.px        <= '0;
      cmd_q.py        <= '0;
      cmd_q.color     <= req.color;
      cmd_q.pal_index <= req.pal_index;
      cmd_q.red       <= req.red;
      cmd_q.green     <= req.green;
      cmd_q.blue      <= req.blue;
      cmd_q.seed      <= req.seed;
      cmd_q.key_in    <= req.key_in;
      xs_q            <= req.x;
      ys_q            <= req.y;
      rem_x_q         <= '0;
      rem_y_q         <= '0;
    end else if (state_q == ST_DIV) begin
      xs_q    <= {xs_q[14:0], 1'b0};
      ys_q    <= {ys_q[14:0], 1'b0};
      rem_x_q <= nx;
      rem_y_q <= ny;
    end
  end

endmodule

// ----- rtl/pfrkd_queue.sv -----
module pfrkd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pfrkd_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pfrkd_pkg::cmd_t cmd_o
);

  localparam int unsigned QAW = $clog2(pfrkd_pkg::QUEUE_DEPTH);

  pfrkd_pkg::cmd_t mem_q [pfrkd_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]  wp_q, rp_q;
  logic [QAW:0]    cnt_q;

  assign full_o  = (cnt_q == (QAW + 1)'(pfrkd_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + QAW'(1);
      end
      if (pop_i) begin
        rp_q <= rp_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QAW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QAW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

endmodule

// ----- rtl/pfrkd_back.sv -----
`include "palette_framebuffer_rng_key_device_assert.svh"

module pfrkd_back #(
  parameter int unsigned MAX_WIDTH      = pfrkd_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT     = pfrkd_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned KEY_RING_DEPTH = pfrkd_pkg::KEY_RING_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pfrkd_pkg::cmd_t cmd_i,
  output logic            pop_o,
  output logic            init_busy_o,
  pfrkd_rsp_if.source     rsp
);

  localparam int unsigned FB_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned FB_AW    = $clog2(FB_CELLS);
  localparam int unsigned RG_AW    = $clog2(KEY_RING_DEPTH);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_CLEAR  = 7'b0000100,
    ST_KEY_RD = 7'b0001000,
    ST_FB_RD  = 7'b0010000,
    ST_PAL_RD = 7'b0100000,
    ST_RESP   = 7'b1000000
  } state_e;

  state_e       state_q;
  logic [FB_AW-1:0] clr_q, pix_addr, fb_waddr;
  logic         fb_we, clearing;
  logic [7:0]   fb_wdata, fb_rdata_q;
  logic [7:0]   fb_mem [FB_CELLS];

  logic [23:0]  pal_mem [pfrkd_pkg::PALETTE_DEPTH];
  logic [pfrkd_pkg::PALETTE_DEPTH-1:0] pal_vld_q;
  logic         pal_we, pal_rvld_q;
  logic [23:0]  pal_rdata_q;
  logic [7:0]   pal_idx_q;

  logic [7:0]   ring_mem [KEY_RING_DEPTH];
  logic [7:0]   ring_rdata_q;
  logic [RG_AW-1:0] head_q, tail_q, nxt_tail, nxt_head;
  logic         ring_we, ring_empty;

  logic [63:0]  rng_q, s1, s2, s3;
  logic [7:0]   res_rand_q, res_char_q;
  logic         res_got_q;
  logic [23:0]  res_pix_q;
  logic         ov_q, load;

  assign clearing    = (state_q == ST_INIT) || (state_q == ST_CLEAR);
  assign init_busy_o = (state_q == ST_INIT);
  assign pop_o       = (state_q == ST_IDLE) && !empty_i;
  assign load        = (state_q == ST_RESP) && (!ov_q || rsp.ready);

  assign pix_addr = FB_AW'(32'(cmd_i.py) * MAX_WIDTH + 32'(cmd_i.px));

  assign s1 = rng_q ^ (rng_q << 13);
  assign s2 = s1 ^ (s1 >> 7);
  assign s3 = s2 ^ (s2 << 17);

  assign nxt_tail   = (tail_q == RG_AW'(KEY_RING_DEPTH - 1)) ? '0 : tail_q + RG_AW'(1);
  assign nxt_head   = (head_q == RG_AW'(KEY_RING_DEPTH - 1)) ? '0 : head_q + RG_AW'(1);
  assign ring_empty = (head_q == tail_q);

  assign fb_we    = clearing || (pop_o && cmd_i.req == pfrkd_pkg::REQ_PLOT);
  assign fb_waddr = clearing ? clr_q : pix_addr;
  assign fb_wdata = clearing ? 8'd0 : cmd_i.color;
  assign pal_we   = pop_o && (cmd_i.req == pfrkd_pkg::REQ_PAL);
  assign ring_we  = pop_o && (cmd_i.req == pfrkd_pkg::REQ_PUSH) && (nxt_tail != head_q);

  assign rsp.valid = ov_q;

  always_ff @(posedge clk_i) begin
    if (fb_we) begin
      fb_mem[fb_waddr] <= fb_wdata;
    end
    fb_rdata_q <= fb_mem[pix_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[cmd_i.pal_index] <= {cmd_i.red, cmd_i.green, cmd_i.blue};
    end
    pal_rdata_q <= pal_mem[fb_rdata_q];
    pal_rvld_q  <= pal_vld_q[fb_rdata_q];
    pal_idx_q   <= fb_rdata_q;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[tail_q] <= cmd_i.key_in;
    end
    ring_rdata_q <= ring_mem[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      clr_q      <= '0;
      pal_vld_q  <= '0;
      head_q     <= '0;
      tail_q     <= '0;
      rng_q      <= pfrkd_pkg::RNG_RESET;
      ov_q       <= 1'b0;
      res_rand_q <= '0;
      res_got_q  <= 1'b0;
      res_char_q <= '0;
      res_pix_q  <= '0;
    end else begin
      if (load) begin
        ov_q <= 1'b1;
      end else if (rsp.ready) begin
        ov_q <= 1'b0;
      end
      if (pal_we) begin
        pal_vld_q[cmd_i.pal_index] <= 1'b1;
      end
      if (ring_we) begin
        tail_q <= nxt_tail;
      end
      case (state_q)
        ST_INIT, ST_CLEAR: begin
          if (clr_q == FB_AW'(FB_CELLS - 1)) begin
            clr_q   <= '0;
            state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
          end else begin
            clr_q <= clr_q + FB_AW'(1);
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            res_rand_q <= (cmd_i.req == pfrkd_pkg::REQ_RAND) ? s3[7:0] : '0;
            res_got_q  <= 1'b0;
            res_char_q <= '0;
            res_pix_q  <= '0;
            case (cmd_i.req)
              pfrkd_pkg::REQ_CLEAR: state_q <= ST_CLEAR;
              pfrkd_pkg::REQ_RAND: begin
                rng_q   <= s3;
                state_q <= ST_RESP;
              end
              pfrkd_pkg::REQ_SEED: begin
                rng_q   <= (cmd_i.seed == '0) ? 64'd1 : cmd_i.seed;
                state_q <= ST_RESP;
              end
              pfrkd_pkg::REQ_POP: state_q <= ring_empty ? ST_RESP : ST_KEY_RD;
              pfrkd_pkg::REQ_READ: state_q <= ST_FB_RD;
              default: state_q <= ST_RESP;
            endcase
          end
        end
        ST_KEY_RD: begin
          res_got_q  <= 1'b1;
          res_char_q <= ring_rdata_q;
          head_q     <= nxt_head;
          state_q    <= ST_RESP;
        end
        ST_FB_RD: state_q <= ST_PAL_RD;
        ST_PAL_RD: begin
          // entries never written keep their power-on colour
          res_pix_q <= pal_rvld_q ? pal_rdata_q : pfrkd_pkg::XTERM[pal_idx_q];
          state_q   <= ST_RESP;
        end
        ST_RESP: begin
          if (load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rsp.rand_byte   <= res_rand_q;
      rsp.key_got     <= res_got_q;
      rsp.key_char    <= res_char_q;
      rsp.pixel_color <= res_pix_q;
    end
  end

  `PFRKD_ASSERT_NEXT(a_push_leaves_room, ring_we, tail_q != head_q, "ring push overran head")
  `PFRKD_ASSERT(a_pop_not_empty, state_q == ST_KEY_RD, !ring_empty, "key read on empty ring")
  `PFRKD_ASSERT_NEXT(a_no_reinit, state_q == ST_IDLE, state_q != ST_INIT, "init sweep restarted")

endmodule

// ----- dv/pfrkd_checker.sv -----
`timescale 1ns / 100ps

module pfrkd_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  pfrkd_req_if  req,
  pfrkd_rsp_if  rsp,
  input  logic  cfg_we_i,
  input  logic  cfg_idx_i,
  input  logic  [8:0] cfg_data_i,
  output int    pending_o,
  output int    fail_count_o
);

  typedef struct packed {
    logic [7:0]  rand_byte;
    logic        key_got;
    logic [7:0]  key_char;
    logic [23:0] pixel_color;
  } reply_t;

  localparam int unsigned FB_W = pfrkd_pkg::MAX_WIDTH_DEF;
  localparam int unsigned FB_CELLS = pfrkd_pkg::MAX_WIDTH_DEF * pfrkd_pkg::MAX_HEIGHT_DEF;

  logic [7:0]  pixels [FB_CELLS];
  logic [23:0] colours [pfrkd_pkg::PALETTE_DEPTH];
  logic [7:0]  keys [pfrkd_pkg::KEY_RING_DEPTH_DEF];
  logic [7:0]  key_head, key_tail;
  logic [63:0] xs_state;
  logic [8:0]  width_reg;
  logic [7:0]  height_reg;
  reply_t      replies_due [$];
  int          fails;

  assign pending_o    = replies_due.size();
  assign fail_count_o = fails;

  function automatic logic [7:0] level(int k);
    return (k == 0) ? 8'd0 : 8'(55 + 40 * k);
  endfunction

  function automatic int unsigned pixel_index(logic [15:0] x, logic [15:0] y);
    int unsigned w, h;
    w = (width_reg == 0) ? 1 :
        (width_reg > pfrkd_pkg::MAX_WIDTH_DEF) ? pfrkd_pkg::MAX_WIDTH_DEF : width_reg;
    h = (height_reg == 0) ? 1 :
        (height_reg > pfrkd_pkg::MAX_HEIGHT_DEF) ? pfrkd_pkg::MAX_HEIGHT_DEF : height_reg;
    return (int'(y) % h) * FB_W + (int'(x) % w);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t      r;
    logic [63:0] s;
    if (!rst_ni) begin
      foreach (pixels[i]) pixels[i] = '0;
      for (int i = 0; i < 16; i++) begin
        colours[i] = {8'(i[0] ? 8'haa : 8'h00), 8'(i[1] ? 8'haa : 8'h00),
                      8'(i[2] ? 8'haa : 8'h00)};
        if (i >= 8) colours[i] = colours[i] | 24'h555555;
      end
      // system colour 3 is brown rather than dark yellow
      colours[3] = 24'haa5500;
      for (int i = 0; i < 216; i++)
        colours[16 + i] = {level(i / 36), level((i / 6) % 6), level(i % 6)};
      for (int i = 0; i < 24; i++)
        colours[232 + i] = {3{8'(8 + 10 * i)}};
      key_head   = '0;
      key_tail   = '0;
      xs_state   = pfrkd_pkg::RNG_RESET;
      width_reg  = pfrkd_pkg::WIDTH_RESET;
      height_reg = pfrkd_pkg::HEIGHT_RESET;
      replies_due.delete();
      fails      = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == pfrkd_pkg::CFG_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i[7:0];
      end
      if (req.valid && req.ready) begin
        r = '0;
        case (pfrkd_pkg::req_e'(req.req_type))
          pfrkd_pkg::REQ_PLOT:  pixels[pixel_index(req.x, req.y)] = req.color;
          pfrkd_pkg::REQ_CLEAR: foreach (pixels[i]) pixels[i] = '0;
          pfrkd_pkg::REQ_PAL:   colours[req.pal_index] = {req.red, req.green, req.blue};
          pfrkd_pkg::REQ_RAND: begin
            s = xs_state;
            s ^= s << 13;
            s ^= s >> 7;
            s ^= s << 17;
            xs_state    = s;
            r.rand_byte = s[7:0];
          end
          pfrkd_pkg::REQ_SEED:  xs_state = (req.seed == 0) ? 64'd1 : req.seed;
          pfrkd_pkg::REQ_PUSH: begin
            if (8'(key_tail + 1) != key_head) begin
              keys[key_tail] = req.key_in;
              key_tail++;
            end
          end
          pfrkd_pkg::REQ_POP: begin
            if (key_head != key_tail) begin
              r.key_got  = 1'b1;
              r.key_char = keys[key_head];
              key_head++;
            end
          end
          default:   r.pixel_color = colours[pixels[pixel_index(req.x, req.y)]];
        endcase
        replies_due.push_back(r);
      end
      if (rsp.valid && rsp.ready) begin
        if (replies_due.size() == 0) begin
          $display("unexpected response transaction at %0t", $realtime);
          fails++;
        end else begin
          r = replies_due.pop_front();
          if (rsp.rand_byte !== r.rand_byte) report("rand_byte", rsp.rand_byte, r.rand_byte);
          if (rsp.key_got !== r.key_got) report("key_got", rsp.key_got, r.key_got);
          if (rsp.key_char !== r.key_char) report("key_char", rsp.key_char, r.key_char);
          if (rsp.pixel_color !== r.pixel_color)
            report("pixel_color", rsp.pixel_color, r.pixel_color);
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    pfrkd_pkg::req_e kind;
    logic [15:0] x, y;
    logic [7:0]  color, pal_index, red, green, blue, key_in;
    logic [63:0] seed;
  } cmd_item_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int HOLD_CYCLES    = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [8:0] cfg_data_i = '0;
  int   pending, fail_count;
  bit   calm = 1'b0;
  int   hold_asked = 0;
  logic [15:0] drawn_x [$], drawn_y [$];

  pfrkd_req_if req ();
  pfrkd_rsp_if rsp ();

  palette_framebuffer_rng_key_device dut (
    .clk_i, .rst_ni, .req, .rsp, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  pfrkd_checker u_checker (
    .clk_i, .rst_ni, .req, .rsp, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    req.valid = 1'b0; req.req_type = '0; req.x = '0; req.y = '0; req.color = '0;
    req.pal_index = '0; req.red = '0; req.green = '0; req.blue = '0;
    req.seed = '0; req.key_in = '0;
    rsp.ready = 1'b0;
  end

  // response side: random stalls, plus a long hold-off on request
  initial begin
    int hold_done;
    hold_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_asked != hold_done) begin
        hold_done = hold_asked;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp.ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic cmd_item_t random_cmd(pfrkd_pkg::req_e kind);
    cmd_item_t c;
    int pick;
    c.kind = kind;
    c.x = 16'($urandom); c.y = 16'($urandom);
    c.color = 8'($urandom); c.pal_index = 8'($urandom);
    c.red = 8'($urandom); c.green = 8'($urandom); c.blue = 8'($urandom);
    c.key_in = 8'($urandom);
    c.seed = {$urandom, $urandom};
    if ($urandom_range(3) == 0) c.seed = '0;
    if ($urandom_range(1) == 0) begin
      c.x = 16'($urandom_range(300));
      c.y = 16'($urandom_range(150));
    end
    // reads mostly revisit recently drawn pixels
    if (kind == pfrkd_pkg::REQ_READ && drawn_x.size() > 0 && $urandom_range(3) != 0) begin
      pick = $urandom_range(drawn_x.size() - 1);
      c.x = drawn_x[pick]; c.y = drawn_y[pick];
    end
    return c;
  endfunction

  task automatic send(cmd_item_t c);
    if (!calm && $urandom_range(99) < 8) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.req_type <= c.kind; req.x <= c.x; req.y <= c.y; req.color <= c.color;
    req.pal_index <= c.pal_index; req.red <= c.red; req.green <= c.green;
    req.blue <= c.blue; req.seed <= c.seed; req.key_in <= c.key_in;
    if (c.kind == pfrkd_pkg::REQ_PLOT) begin
      drawn_x.push_back(c.x); drawn_y.push_back(c.y);
      if (drawn_x.size() > 16) begin
        void'(drawn_x.pop_front()); void'(drawn_y.pop_front());
      end
    end
    do @(posedge clk_i); while (!req.ready);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_size(logic [8:0] w, logic [8:0] h);
    cfg_we_i <= 1'b1; cfg_idx_i <= pfrkd_pkg::CFG_WIDTH; cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= pfrkd_pkg::CFG_HEIGHT; cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_phase(int n);
    int dice;
    pfrkd_pkg::req_e k;
    for (int i = 0; i < n; i++) begin
      dice = $urandom_range(999);
      if (dice < 250) k = pfrkd_pkg::REQ_PLOT;
      else if (dice < 500) k = pfrkd_pkg::REQ_READ;
      else if (dice < 600) k = pfrkd_pkg::REQ_PAL;
      else if (dice < 700) k = pfrkd_pkg::REQ_RAND;
      else if (dice < 750) k = pfrkd_pkg::REQ_SEED;
      else if (dice < 870) k = pfrkd_pkg::REQ_PUSH;
      else if (dice < 992) k = pfrkd_pkg::REQ_POP;
      else k = pfrkd_pkg::REQ_CLEAR;
      send(random_cmd(k));
    end
  endtask

  initial begin
    cmd_item_t c;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes of coordinates and data, each request kind
    c = random_cmd(pfrkd_pkg::REQ_POP); send(c);
    c = random_cmd(pfrkd_pkg::REQ_READ); c.x = 16'hffff; c.y = 16'hffff; send(c);
    c = random_cmd(pfrkd_pkg::REQ_PLOT); c.x = '0; c.y = '0; c.color = 8'hff; send(c);
    c = random_cmd(pfrkd_pkg::REQ_PLOT); c.x = 16'hffff; c.y = 16'hffff;
    c.color = 8'h10; send(c);
    c = random_cmd(pfrkd_pkg::REQ_PLOT); c.x = 16'd63; c.y = 16'd47; c.color = 8'he7; send(c);
    c = random_cmd(pfrkd_pkg::REQ_READ); c.x = '0; c.y = '0; send(c);
    c = random_cmd(pfrkd_pkg::REQ_READ); c.x = 16'hffff; c.y = 16'hffff; send(c);
    c = random_cmd(pfrkd_pkg::REQ_READ); c.x = 16'd127; c.y = 16'd95; send(c);
    c = random_cmd(pfrkd_pkg::REQ_PAL); c.pal_index = 8'hff; c.red = 8'hff; c.green = '0;
    c.blue = 8'hff; send(c);
    c = random_cmd(pfrkd_pkg::REQ_PAL); c.pal_index = '0; c.red = '0; c.green = 8'hff;
    c.blue = '0; send(c);
    c = random_cmd(pfrkd_pkg::REQ_READ); c.x = 16'd64; c.y = 16'd48; send(c);
    c = random_cmd(pfrkd_pkg::REQ_RAND); send(c);
    c = random_cmd(pfrkd_pkg::REQ_RAND); send(c);
    c = random_cmd(pfrkd_pkg::REQ_SEED); c.seed = '0; send(c);
    c = random_cmd(pfrkd_pkg::REQ_RAND); send(c);
    c = random_cmd(pfrkd_pkg::REQ_SEED); c.seed = '1; send(c);
    c = random_cmd(pfrkd_pkg::REQ_RAND); send(c);
    c = random_cmd(pfrkd_pkg::REQ_PUSH); c.key_in = 8'hff; send(c);
    c = random_cmd(pfrkd_pkg::REQ_PUSH); c.key_in = '0; send(c);
    c = random_cmd(pfrkd_pkg::REQ_POP); send(c);
    c = random_cmd(pfrkd_pkg::REQ_POP); send(c);
    c = random_cmd(pfrkd_pkg::REQ_POP); send(c);
    c = random_cmd(pfrkd_pkg::REQ_CLEAR); send(c);
    c = random_cmd(pfrkd_pkg::REQ_READ); c.x = 16'hffff; c.y = 16'hffff; send(c);
    drain();

    // zero sizes behave as one
    set_size(9'd0, 9'd0);
    random_phase(60);
    drain();

    // largest legal sizes, no idling, ring filled past capacity
    set_size(9'd256, 9'd128);
    calm = 1'b1;
    for (int i = 0; i < 262; i++) begin
      c = random_cmd(pfrkd_pkg::REQ_PUSH); send(c);
    end
    random_phase(60);
    calm = 1'b0;
    drain();

    // oversized registers clamp; response side stalls while requests pile up
    set_size(9'h1ff, 9'hff);
    random_phase(20);
    hold_asked++;
    random_phase(60);
    drain();

    set_size(9'd1, 9'd128);
    random_phase(60);
    drain();

    set_size(9'($urandom_range(2, 255)), 9'($urandom_range(2, 127)));
    random_phase(70);
    drain();

    set_size(9'd256, 9'd1);
    random_phase(60);
    drain();
    repeat (100) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/pfrkd_pkg.sv
rtl/pfrkd_if.sv
rtl/pfrkd_front.sv
rtl/pfrkd_queue.sv
rtl/pfrkd_back.sv
rtl/palette_framebuffer_rng_key_device.sv
dv/pfrkd_checker.sv
dv/tb_top.sv
